/* rtl/core/ccds_pkg.sv */
package ccds_pkg;

  // Width of every frequency in hertz.
  localparam int unsigned HzW = 32;

  // Divider field width on the result port.
  localparam int unsigned DivFieldW = 8;

  // Card clock is input clock over (divider + DivOffset).
  localparam int unsigned DivOffset = 2;

  localparam int unsigned DividerMaxDef = 255;

  localparam logic [HzW-1:0] InputClockRst = 32'd100000000;
  localparam logic [HzW-1:0] MaxCardClockRst = 32'd50000000;

  typedef logic [HzW-1:0] hz_t;
  typedef logic [HzW:0] den_t;

  typedef enum logic {
    REG_INPUT_CLOCK    = 1'b0,
    REG_MAX_CARD_CLOCK = 1'b1
  } cfg_reg_e;

endpackage

/* rtl/core/ccds_div.sv */
module ccds_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           go_i,
  input  ccds_pkg::hz_t  dividend_i,
  input  ccds_pkg::den_t divisor_i,
  output logic           done_o,
  output ccds_pkg::hz_t  quotient_o
);
  import ccds_pkg::*;

  localparam int unsigned CntW = $clog2(HzW);

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [HzW:0]    rem_q, rem_d;
  hz_t             quo_q, quo_d;
  den_t            den_q, den_d;
  logic [HzW+1:0]  shifted;
  logic [HzW+1:0]  den_ext;
  logic            fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign shifted = {rem_q, quo_q[HzW-1]};
  assign den_ext = {1'b0, den_q};
  assign fits    = (shifted >= den_ext);

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (go_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = dividend_i;
      den_d = divisor_i;
    end else if (run_q) begin
      rem_d = fits ? (HzW+1)'(shifted - den_ext) : shifted[HzW:0];
      quo_d = {quo_q[HzW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(HzW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/core/card_clock_divider_select.sv */
// Card clock divider select.
//
// Command channel: drive requested_hz_i and raise start_i; the beat is taken
// at a rising edge where start_i is high and busy_o is low. busy_o stays high
// until the search is over. The result beat (applied_o, divider_o,
// achieved_hz_o) is shown for exactly one cycle, marked by done_o; the
// receiver cannot stall it, so sample it in that cycle.
// A zero request gives applied_o = 0 with zero fields in the cycle after start.
// Any other request runs through one shared bit-serial divider:
// input/request (skipped when the request is at or above the maximum),
// input/(target+1), then input/(divider+2). busy_o drops as done_o rises,
// so a new start beat can be taken at the edge that takes the result; a
// zero request leaves busy_o low throughout.
// Configuration: cfg_we_i, cfg_addr_i and cfg_wdata_i write the input clock
// (index 0) or the maximum card clock (index 1); write only
// while busy_o is low. Reset returns both registers to 100 MHz and 50 MHz,
// drops any search in progress and clears the strobe.
module card_clock_divider_select #(
  parameter int unsigned DIVIDER_MAX = ccds_pkg::DividerMaxDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_addr_i,
  input  ccds_pkg::hz_t                     cfg_wdata_i,
  input  logic                              start_i,
  output logic                              busy_o,
  input  ccds_pkg::hz_t                     requested_hz_i,
  output logic                              done_o,
  output logic                              applied_o,
  output logic [ccds_pkg::DivFieldW-1:0]    divider_o,
  output ccds_pkg::hz_t                     achieved_hz_o
);
  import ccds_pkg::*;

  localparam int unsigned DivW = $clog2(DIVIDER_MAX + 1);
  localparam hz_t DivMax = HzW'(DIVIDER_MAX);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUOT,
    ST_LEAST,
    ST_ACHV
  } state_e;

  state_e          state_q, state_d;
  hz_t             in_clk_q, max_clk_q;
  hz_t             target_q, target_d;
  hz_t             from_q, from_d;
  logic [DivW-1:0] div_q, div_d;
  logic            go_q, go_d;
  den_t            den_q, den_d;
  logic            done_q, done_d;
  logic            applied_q, applied_d;
  logic [DivFieldW-1:0] field_q, field_d;
  hz_t             achv_q, achv_d;

  logic            unit_done;
  hz_t             unit_quo;
  hz_t             from_quot, least, pick;
  logic [DivW-1:0] div_sat;
  hz_t             div_wide;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_clk_q  <= InputClockRst;
      max_clk_q <= MaxCardClockRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_INPUT_CLOCK:    in_clk_q  <= cfg_wdata_i;
        REG_MAX_CARD_CLOCK: max_clk_q <= cfg_wdata_i;
        default:            ;
      endcase
    end
  end

  ccds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (go_q),
    .dividend_i (in_clk_q),
    .divisor_i  (den_q),
    .done_o     (unit_done),
    .quotient_o (unit_quo)
  );

  // Start point from input/request, clamped at zero instead of wrapping.
  assign from_quot = (unit_quo >= HzW'(DivOffset)) ? unit_quo - HzW'(DivOffset) : '0;
  // Least divider meeting the target: floor(input/(target+1)) - 1.
  assign least     = (unit_quo >= HzW'(1)) ? unit_quo - HzW'(1) : '0;
  assign pick      = (least > from_q) ? least : from_q;
  assign div_sat   = (pick > DivMax) ? DivW'(DIVIDER_MAX) : DivW'(pick);
  assign div_wide  = HzW'(div_q);

  always_comb begin
    state_d   = state_q;
    target_d  = target_q;
    from_d    = from_q;
    div_d     = div_q;
    go_d      = 1'b0;
    den_d     = den_q;
    done_d    = 1'b0;
    applied_d = applied_q;
    field_d   = field_q;
    achv_d    = achv_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (requested_hz_i == '0) begin
            done_d    = 1'b1;
            applied_d = 1'b0;
            field_d   = '0;
            achv_d    = '0;
          end else if (requested_hz_i >= max_clk_q) begin
            target_d = max_clk_q;
            from_d   = '0;
            go_d     = 1'b1;
            den_d    = {1'b0, max_clk_q} + den_t'(1);
            state_d  = ST_LEAST;
          end else begin
            target_d = requested_hz_i;
            go_d     = 1'b1;
            den_d    = {1'b0, requested_hz_i};
            state_d  = ST_QUOT;
          end
        end
      end
      ST_QUOT: begin
        if (unit_done) begin
          from_d  = from_quot;
          go_d    = 1'b1;
          den_d   = {1'b0, target_q} + den_t'(1);
          state_d = ST_LEAST;
        end
      end
      ST_LEAST: begin
        if (unit_done) begin
          div_d   = div_sat;
          go_d    = 1'b1;
          den_d   = den_t'(div_sat) + den_t'(DivOffset);
          state_d = ST_ACHV;
        end
      end
      ST_ACHV: begin
        if (unit_done) begin
          done_d    = 1'b1;
          applied_d = 1'b1;
          field_d   = div_wide[DivFieldW-1:0];
          achv_d    = unit_quo;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state, strobe and the result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      go_q      <= 1'b0;
      done_q    <= 1'b0;
      applied_q <= 1'b0;
      field_q   <= '0;
      achv_q    <= '0;
    end else begin
      state_q   <= state_d;
      go_q      <= go_d;
      done_q    <= done_d;
      applied_q <= applied_d;
      field_q   <= field_d;
      achv_q    <= achv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    from_q   <= from_d;
    div_q    <= div_d;
    den_q    <= den_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign applied_o     = applied_q;
  assign divider_o     = field_q;
  assign achieved_hz_o = achv_q;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ccds_pkg::*;

  // Run limits, in clock cycles.
  localparam int unsigned CycleLimit = 500000;
  // Idle cycles before a register write; every request yields a beat, so a few do.
  localparam int unsigned QuietCyc = 4;
  // Drain after the last result: a bit more than the longest search.
  localparam int unsigned TailCyc = 120;
  localparam int unsigned RandPhases = 8;
  localparam int unsigned ReqsPerPhase = 92;

  typedef struct {
    bit          is_cfg;
    cfg_reg_e    reg_sel;
    hz_t         value;   // request, or register data for a write
    int unsigned gap;     // idle cycles before this command
  } host_cmd_t;

  typedef struct {
    logic                 applied;
    logic [DivFieldW-1:0] divider;
    hz_t                  achieved_hz;
  } clk_setting_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_addr_i = REG_INPUT_CLOCK;
  hz_t cfg_wdata_i = '0;
  logic start_i = 1'b0;
  hz_t requested_hz_i = '0;
  logic busy_o;
  logic done_o;
  logic applied_o;
  logic [DivFieldW-1:0] divider_o;
  hz_t achieved_hz_o;

  host_cmd_t    pending_cmds[$];
  clk_setting_t expected_settings[$];

  // Register copies as the block sees them, updated when a write is driven.
  hz_t cur_input_clk = InputClockRst;
  hz_t cur_max_clk = MaxCardClockRst;
  // Register values as planned by the stimulus, ahead of the driver.
  hz_t plan_input_clk = InputClockRst;
  hz_t plan_max_clk = MaxCardClockRst;

  bit          cmd_taken = 1'b0;
  bit          gap_done = 1'b0;
  int unsigned gap_left = 0;
  int unsigned quiet_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          use_gaps = 1'b1;

  card_clock_divider_select u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .requested_hz_i (requested_hz_i),
    .done_o         (done_o),
    .applied_o      (applied_o),
    .divider_o      (divider_o),
    .achieved_hz_o  (achieved_hz_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Expected divider choice for one request under the current registers.
  // Widen to 64 bits so target + 1 cannot wrap at the top of the range.
  function automatic clk_setting_t pick_divider(hz_t req_hz);
    clk_setting_t     res;
    longint unsigned  src;
    longint unsigned  req;
    longint unsigned  target;
    longint unsigned  first_div;
    longint unsigned  least_div;
    longint unsigned  quo;
    longint unsigned  div;
    res = '{applied: 1'b0, divider: '0, achieved_hz: '0};
    src = cur_input_clk;
    req = req_hz;
    if (req != 0) begin
      if (req >= cur_max_clk) begin
        // Limit to the maximum and search from divider zero.
        target = cur_max_clk;
        first_div = 0;
      end else begin
        target = req;
        quo = src / req;
        // A quotient below two would wrap; start from zero instead.
        first_div = (quo >= DivOffset) ? quo - DivOffset : 0;
      end
      quo = src / (target + 1);
      least_div = (quo >= 1) ? quo - 1 : 0;
      div = (least_div > first_div) ? least_div : first_div;
      if (div > DividerMaxDef) div = DividerMaxDef;
      res.applied = 1'b1;
      res.divider = div[DivFieldW-1:0];
      res.achieved_hz = hz_t'(src / (div + DivOffset));
    end
    return res;
  endfunction

  // Driver: present one beat at a time at the falling edge, holding it until taken.
  always @(negedge clk_i) begin
    logic     nx_start;
    hz_t      nx_req;
    logic     nx_we;
    logic     nx_addr;
    hz_t      nx_wdata;
    host_cmd_t head;
    nx_start = start_i;
    nx_req = requested_hz_i;
    nx_we = 1'b0;
    nx_addr = cfg_addr_i;
    nx_wdata = cfg_wdata_i;
    if (rst_ni) begin
      if (start_i && !cmd_taken) begin
        // Hold the beat until the block takes it.
      end else begin
        nx_start = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
          // Wiggle the request while start is low; the block must ignore it.
          nx_req = $urandom();
        end else if (pending_cmds.size() != 0) begin
          head = pending_cmds[0];
          if (!gap_done && head.gap != 0) begin
            gap_left = head.gap - 1;
            gap_done = 1'b1;
            nx_req = $urandom();
          end else if (head.is_cfg) begin
            // Write only once every result has come and the block is idle.
            if (expected_settings.size() == 0 && !busy_o) quiet_cnt++;
            else quiet_cnt = 0;
            if (quiet_cnt >= QuietCyc) begin
              nx_we = 1'b1;
              nx_addr = head.reg_sel;
              nx_wdata = head.value;
              if (head.reg_sel == REG_INPUT_CLOCK) cur_input_clk = head.value;
              else cur_max_clk = head.value;
              void'(pending_cmds.pop_front());
              gap_done = 1'b0;
              quiet_cnt = 0;
            end
          end else begin
            nx_start = 1'b1;
            nx_req = head.value;
            void'(pending_cmds.pop_front());
            gap_done = 1'b0;
          end
        end
      end
    end
    start_i <= nx_start;
    requested_hz_i <= nx_req;
    cfg_we_i <= nx_we;
    cfg_addr_i <= nx_addr;
    cfg_wdata_i <= nx_wdata;
  end

  // Monitor: check result beats against the oldest prediction, then record new beats.
  always @(posedge clk_i) begin
    clk_setting_t exp_set;
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("card_clock_divider_select: mismatch");
      $finish;
    end else if (rst_ni) begin
      if (done_o) begin
        if (expected_settings.size() == 0) begin
          $error("result beat with nothing expected");
          fail_cnt++;
        end else begin
          exp_set = expected_settings.pop_front();
          if (applied_o !== exp_set.applied) begin
            $error("applied: expected %0d, got %0d", exp_set.applied, applied_o);
            fail_cnt++;
          end
          if (divider_o !== exp_set.divider) begin
            $error("divider: expected %0d, got %0d", exp_set.divider, divider_o);
            fail_cnt++;
          end
          if (achieved_hz_o !== exp_set.achieved_hz) begin
            $error("achieved_hz: expected %0d, got %0d", exp_set.achieved_hz,
                   achieved_hz_o);
            fail_cnt++;
          end
        end
      end
      if (start_i && !busy_o) expected_settings.push_back(pick_divider(requested_hz_i));
      cmd_taken <= start_i && !busy_o;
    end
  end

  task automatic add_req(hz_t req_hz);
    host_cmd_t cmd;
    cmd.is_cfg = 1'b0;
    cmd.reg_sel = REG_INPUT_CLOCK;
    cmd.value = req_hz;
    cmd.gap = use_gaps ? $urandom_range(0, 18) : 0;
    pending_cmds.push_back(cmd);
  endtask

  task automatic add_cfg(hz_t src_hz, hz_t max_hz);
    host_cmd_t cmd;
    cmd.is_cfg = 1'b1;
    cmd.gap = 0;
    cmd.reg_sel = REG_INPUT_CLOCK;
    cmd.value = src_hz;
    pending_cmds.push_back(cmd);
    cmd.reg_sel = REG_MAX_CARD_CLOCK;
    cmd.value = max_hz;
    pending_cmds.push_back(cmd);
    plan_input_clk = src_hz;
    plan_max_clk = max_hz;
  endtask

  // Mix of requests aimed at divider boundaries, the limit and plain noise.
  task automatic add_random_reqs(int unsigned count);
    hz_t r;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: r = '0;
        1: r = $urandom();
        2: r = $urandom() >> $urandom_range(0, 31);
        3: r = plan_max_clk + $urandom_range(0, 4) - 2;
        4, 5: r = plan_input_clk / $urandom_range(1, 300) + $urandom_range(0, 2) - 1;
        6: r = plan_input_clk / $urandom_range(2, 258);
        7: r = $urandom_range(1, 1000);
        8: r = (plan_max_clk == 0) ? $urandom() : $urandom() % plan_max_clk;
        default: r = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
      endcase
      add_req(r);
    end
  endtask

  initial begin
    hz_t src_hz;
    hz_t max_hz;

    // Directed: reset registers, edges of the request range and divider boundaries.
    add_req(32'd0);
    add_req(32'd1);
    add_req(32'hFFFF_FFFF);
    add_req(32'd50000000);
    add_req(32'd49999999);
    add_req(32'd50000001);
    add_req(32'd100000000);
    add_req(32'd33333334);
    add_req(32'd33333333);
    add_req(32'd400000);
    add_req(32'd392157);
    add_req(32'd392156);
    add_req(32'd2);
    add_req(32'hAAAA_AAAA);
    add_req(32'h5555_5555);
    // Quotient below two: maximum above half the source clock.
    add_cfg(32'd100000000, 32'd200000000);
    add_req(32'd60000000);
    add_req(32'd99999999);
    // Zero source clock.
    add_cfg(32'd0, 32'd200000000);
    add_req(32'd12345);
    add_req(32'd7);
    // Zero maximum: the divider saturates.
    add_cfg(32'd100000000, 32'd0);
    add_req(32'd1);
    add_req(32'd5);
    // Top of both registers.
    add_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(32'hFFFF_FFFF);
    add_req(32'hFFFF_FFFE);
    add_req(32'd1);

    // Random phases, each under a fresh register setting.
    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      use_gaps = (ph % 3) != 1;
      case ($urandom_range(0, 5))
        0: src_hz = $urandom();
        1: src_hz = $urandom_range(10000000, 400000000);
        2: src_hz = $urandom_range(0, 1000);
        3: src_hz = 32'hFFFF_FFFF;
        4: src_hz = 32'd1;
        default: src_hz = InputClockRst;
      endcase
      case ($urandom_range(0, 5))
        0: max_hz = $urandom();
        1: max_hz = src_hz >> 1;
        2: max_hz = $urandom_range(100000, 52000000);
        3: max_hz = 32'hFFFF_FFFF;
        4: max_hz = $urandom_range(0, 1);
        default: max_hz = src_hz;
      endcase
      if (ph == 0) begin
        src_hz = 32'd1;
        max_hz = 32'd1;
      end else if (ph == RandPhases - 1) begin
        src_hz = InputClockRst;
        max_hz = MaxCardClockRst;
      end
      add_cfg(src_hz, max_hz);
      add_random_reqs(ReqsPerPhase);
    end

    // Reset once, released away from the rising edge.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all commands sent, the last beat taken, every result back.
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || start_i || expected_settings.size() != 0);
    repeat (TailCyc) @(negedge clk_i);

    // A result still owed at the end counts as a failure.
    if (fail_cnt == 0 && expected_settings.size() == 0 && !start_i) begin
      $display("card_clock_divider_select: match");
    end else begin
      $display("card_clock_divider_select: mismatch");
    end
    $finish;
  end

endmodule
